### rtl/core/llss_pkg.sv
// shared types, constants and saturating helpers for the least-loaded server selector
// no dependencies; imported by llss_ctrl, llss_dp and the top level
`default_nettype none

package llss_pkg;

    localparam int SERVER_SLOTS = 16;
    localparam int SLOT_W       = 4;
    localparam int ADDR_W       = (SERVER_SLOTS > 1) ? $clog2(SERVER_SLOTS) : 1;
    localparam int TOTAL_W      = 20;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [15:0]        USERS_MAX = 16'hFFFF;

    // request codes
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_COUNT    = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;
    localparam logic [1:0] REQ_ASSIGN   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_NO_SERVER  = 3'd1;
    localparam logic [2:0] ST_ALL_FULL   = 3'd2;
    localparam logic [2:0] ST_SLOT_EMPTY = 3'd3;
    localparam logic [2:0] ST_SLOT_TAKEN = 3'd4;

    typedef struct packed {
        logic [31:0] primary_ip;
        logic [31:0] backup_ip;
        logic [15:0] port;
        logic [15:0] limit;
        logic [15:0] users;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        RD_SLOT,
        RD_SCAN,
        RD_BEST
    } rd_sel_t;

    // command bundle from controller to datapath
    typedef struct packed {
        logic              load;
        rd_sel_t           rd_sel;
        logic [ADDR_W-1:0] scan_addr;
        logic              cmp;
        logic              update;
        logic              report;
    } llss_cmd_t;

    function automatic logic [TOTAL_W-1:0] total_add(input logic [TOTAL_W-1:0] t,
                                                     input logic [TOTAL_W-1:0] v);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + {1'b0, v};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] total_sub(input logic [TOTAL_W-1:0] t,
                                                     input logic [TOTAL_W-1:0] v);
        return (v >= t) ? '0 : t - v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/least_loaded_server_selector.sv
// top level of the least-loaded server selector
// depends on llss_pkg, llss_ctrl, llss_dp (and llss_ram through llss_dp)
`default_nettype none

// Usage
//   request channel: drive the request fields and raise start; the request is
//   transferred at the rising edge where start is high and busy is low. busy
//   stays high from the cycle after the transfer until the result is shown.
//   result channel: done is high for exactly one cycle while status,
//   assigned_* and total_users carry the result; the receiver cannot stall,
//   so each result must be taken in that cycle. result ports hold their
//   value until the next result.
//   steps: register, count change and remove go through slot read, table
//   update and result; an assignment goes through scan, last compare, best
//   entry read, report and result. the slot scan reads one table entry
//   per cycle through the single ram read port.
//   a new request may be transferred in the same cycle done is high.
//   reset: rst_n clears the valid bits of all slots and the running total;
//   the table ram itself is not cleared, entries are written before use.

module least_loaded_server_selector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    req_type,
    input  wire logic [3:0]                    server_slot,
    input  wire logic [31:0]                   primary_ip,
    input  wire logic [31:0]                   backup_ip,
    input  wire logic [15:0]                   server_port,
    input  wire logic [15:0]                   user_limit,
    input  wire logic [15:0]                   initial_users,
    input  wire logic                          count_up,
    output logic                               done,
    output logic      [2:0]                    status,
    output logic      [3:0]                    assigned_slot,
    output logic      [31:0]                   assigned_primary_ip,
    output logic      [31:0]                   assigned_backup_ip,
    output logic      [15:0]                   assigned_port,
    output logic      [llss_pkg::TOTAL_W-1:0]  total_users
);

    import llss_pkg::*;

    // command bundle: controller steers the datapath each cycle
    llss_cmd_t cmd;

    // sequencing: decode on transfer, slot read, update or scan, report
    llss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    // table, running total, scan compare and result registers
    llss_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .req_type            (req_type),
        .server_slot         (server_slot),
        .primary_ip          (primary_ip),
        .backup_ip           (backup_ip),
        .server_port         (server_port),
        .user_limit          (user_limit),
        .initial_users       (initial_users),
        .count_up            (count_up),
        .status              (status),
        .assigned_slot       (assigned_slot),
        .assigned_primary_ip (assigned_primary_ip),
        .assigned_backup_ip  (assigned_backup_ip),
        .assigned_port       (assigned_port),
        .total_users         (total_users)
    );

endmodule

`default_nettype wire

### rtl/core/llss_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module llss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/llss_ctrl.sv
// controller for the least-loaded server selector: request sequencing and slot scan
// depends on llss_pkg
`default_nettype none

module llss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        req_type,
    output logic                   busy,
    output logic                   done,
    output llss_pkg::llss_cmd_t    cmd
);

    import llss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_SCAN,
        S_SCAN_END,
        S_FETCH,
        S_REPORT
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SERVER_SLOTS - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.rd_sel    = RD_SLOT;
        cmd.scan_addr = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = (req_type == REQ_ASSIGN) ? S_SCAN : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // read slot cnt, compare the slot read in the previous cycle
                cmd.rd_sel = RD_SCAN;
                cmd.cmp    = (cnt_reg != '0);
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN_END:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.rd_sel = RD_BEST;
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef ASSERT_OFF
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not make the block busy");
`endif

endmodule

`default_nettype wire

### rtl/core/llss_dp.sv
// datapath for the least-loaded server selector: server table, running total, scan compare
// depends on llss_pkg and llss_ram
`default_nettype none

module llss_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire llss_pkg::llss_cmd_t            cmd,
    input  wire logic [1:0]                     req_type,
    input  wire logic [3:0]                     server_slot,
    input  wire logic [31:0]                    primary_ip,
    input  wire logic [31:0]                    backup_ip,
    input  wire logic [15:0]                    server_port,
    input  wire logic [15:0]                    user_limit,
    input  wire logic [15:0]                    initial_users,
    input  wire logic                           count_up,
    output logic      [2:0]                     status,
    output logic      [3:0]                     assigned_slot,
    output logic      [31:0]                    assigned_primary_ip,
    output logic      [31:0]                    assigned_backup_ip,
    output logic      [15:0]                    assigned_port,
    output logic      [llss_pkg::TOTAL_W-1:0]   total_users
);

    import llss_pkg::*;

    // latched request
    logic [1:0]        req_reg;
    logic [SLOT_W-1:0] slot_reg;
    entry_t            new_entry_reg;
    logic              up_reg;

    // table state
    logic [SERVER_SLOTS-1:0] valid_reg, valid_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;

    // scan state
    logic              any_reg, any_next;
    logic              found_reg, found_next;
    logic [15:0]       best_users_reg, best_users_next;
    logic [ADDR_W-1:0] best_slot_reg, best_slot_next;
    logic [ADDR_W-1:0] rd_addr_reg;

    // result registers
    logic [2:0]         status_reg, status_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic [31:0]        rpip_reg, rpip_next;
    logic [31:0]        rbip_reg, rbip_next;
    logic [15:0]        rport_reg, rport_next;
    logic [TOTAL_W-1:0] rtotal_reg, rtotal_next;

    // table ram
    logic              we;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] slot_addr;
    entry_t            wr_entry;
    logic [ENTRY_W-1:0] rdata;
    entry_t            rd_entry;
    logic              slot_ok;
    logic              slot_valid;

    assign slot_addr  = ADDR_W'(slot_reg);
    assign rd_entry   = entry_t'(rdata);
    assign slot_ok    = (int'(slot_reg) < SERVER_SLOTS);
    assign slot_valid = slot_ok && valid_reg[slot_addr];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN: rd_addr = cmd.scan_addr;
            RD_BEST: rd_addr = best_slot_reg;
            default: rd_addr = slot_addr;
        endcase
    end

    llss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SERVER_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (slot_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // scan compare: strict less-than in ascending order keeps the lowest slot on ties
    always_comb
    begin
        any_next        = any_reg;
        found_next      = found_reg;
        best_users_next = best_users_reg;
        best_slot_next  = best_slot_reg;
        if (cmd.load)
        begin
            any_next       = 1'b0;
            found_next     = 1'b0;
            best_slot_next = '0;
        end
        else if (cmd.cmp && valid_reg[rd_addr_reg])
        begin
            any_next = 1'b1;
            if ((rd_entry.users < rd_entry.limit) &&
                (!found_reg || (rd_entry.users < best_users_reg)))
            begin
                found_next      = 1'b1;
                best_users_next = rd_entry.users;
                best_slot_next  = rd_addr_reg;
            end
        end
    end

    // table update and result formation
    always_comb
    begin
        we          = 1'b0;
        wr_entry    = rd_entry;
        valid_next  = valid_reg;
        total_next  = total_reg;
        status_next = status_reg;
        rslot_next  = rslot_reg;
        rpip_next   = rpip_reg;
        rbip_next   = rbip_reg;
        rport_next  = rport_reg;
        rtotal_next = rtotal_reg;

        if (cmd.update)
        begin
            status_next = ST_DONE;
            case (req_reg)
                REQ_REGISTER:
                begin
                    if (!slot_ok)
                    begin
                        status_next = ST_SLOT_EMPTY;
                    end
                    else if (slot_valid)
                    begin
                        status_next = ST_SLOT_TAKEN;
                    end
                    else
                    begin
                        we                    = 1'b1;
                        wr_entry              = new_entry_reg;
                        valid_next[slot_addr] = 1'b1;
                        total_next = total_add(total_reg, TOTAL_W'(new_entry_reg.users));
                    end
                end
                REQ_COUNT:
                begin
                    if (!slot_valid)
                    begin
                        status_next = ST_SLOT_EMPTY;
                    end
                    else if (up_reg)
                    begin
                        if (rd_entry.users != USERS_MAX)
                        begin
                            we             = 1'b1;
                            wr_entry.users = rd_entry.users + 16'd1;
                            total_next     = total_add(total_reg, TOTAL_W'(1));
                        end
                    end
                    else if (rd_entry.users != 16'd0)
                    begin
                        we             = 1'b1;
                        wr_entry.users = rd_entry.users - 16'd1;
                        total_next     = total_sub(total_reg, TOTAL_W'(1));
                    end
                end
                default:
                begin
                    if (!slot_valid)
                    begin
                        status_next = ST_SLOT_EMPTY;
                    end
                    else
                    begin
                        valid_next[slot_addr] = 1'b0;
                        total_next = total_sub(total_reg, TOTAL_W'(rd_entry.users));
                    end
                end
            endcase
            rslot_next  = '0;
            rpip_next   = '0;
            rbip_next   = '0;
            rport_next  = '0;
            rtotal_next = total_next;
        end
        else if (cmd.report)
        begin
            rtotal_next = total_reg;
            if (!any_reg || !found_reg)
            begin
                status_next = any_reg ? ST_ALL_FULL : ST_NO_SERVER;
                rslot_next  = '0;
                rpip_next   = '0;
                rbip_next   = '0;
                rport_next  = '0;
            end
            else
            begin
                status_next = ST_DONE;
                rslot_next  = SLOT_W'(best_slot_reg);
                rpip_next   = rd_entry.primary_ip;
                rbip_next   = rd_entry.backup_ip;
                rport_next  = rd_entry.port;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
            any_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            total_reg <= total_next;
            any_reg   <= any_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg                  <= req_type;
            slot_reg                 <= server_slot;
            new_entry_reg.primary_ip <= primary_ip;
            new_entry_reg.backup_ip  <= backup_ip;
            new_entry_reg.port       <= server_port;
            new_entry_reg.limit      <= user_limit;
            new_entry_reg.users      <= initial_users;
            up_reg                   <= count_up;
        end
        rd_addr_reg    <= rd_addr;
        best_users_reg <= best_users_next;
        best_slot_reg  <= best_slot_next;
        status_reg     <= status_next;
        rslot_reg      <= rslot_next;
        rpip_reg       <= rpip_next;
        rbip_reg       <= rbip_next;
        rport_reg      <= rport_next;
        rtotal_reg     <= rtotal_next;
    end

    assign status              = status_reg;
    assign assigned_slot       = rslot_reg;
    assign assigned_primary_ip = rpip_reg;
    assign assigned_backup_ip  = rbip_reg;
    assign assigned_port       = rport_reg;
    assign total_users         = rtotal_reg;

`ifndef ASSERT_OFF
    a_found_needs_any: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> any_reg)
        else $error("server chosen without any registered slot");

    a_no_write_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cmp || cmd.report) |-> !we)
        else $error("table written during an assignment");

    a_total_steady_on_assign: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> $stable(total_reg))
        else $error("running total moved on an assignment");
`endif

endmodule

`default_nettype wire
